// ----- hw/rtl/ctc_pkg.sv -----
package ctc_pkg;

  // Run machine of one channel
  typedef enum logic [1:0] {
    RS_RESET     = 2'd0,
    RS_WAIT_TC   = 2'd1,
    RS_WAIT_TRIG = 2'd2,
    RS_RUN       = 2'd3
  } run_t;

  // Control word bits (data byte bits 7..2)
  localparam int CW_TC_FOLLOWS = 0;
  localparam int CW_TRIG_START = 1;
  localparam int CW_RISING     = 2;
  localparam int CW_PRE256     = 3;
  localparam int CW_COUNTER    = 4;
  localparam int CW_INT_EN     = 5;

  // Data byte bits while a control word is written
  localparam int DB_CONTROL    = 0;
  localparam int DB_SOFT_RESET = 1;
  localparam int DB_TC_FOLLOWS = 2;
  localparam int DB_RISING     = 4;

  localparam int TDATA_W = 16;

  typedef struct packed {
    run_t       run_state;
    logic [5:0] control_word;
    logic [7:0] time_constant;
    logic [7:0] prescaler;
    logic [7:0] down_counter;
    logic       counter_was_zero;
    logic       strobe_prev;
    logic       trigger_prev;
  } chan_state_t;

  typedef struct packed {
    logic       write_strobe;
    logic [7:0] write_data;
    logic       trigger_level;
    logic       int_enable_write;
    logic       int_enable_value;
  } item_t;

  typedef struct packed {
    logic       zero_count_pulse;
    logic [7:0] counter_value;
    logic       interrupt_enabled;
    logic       expecting_constant;
  } result_t;

endpackage

// ----- hw/rtl/ctc_chan_step.sv -----
module ctc_chan_step (
  input  ctc_pkg::chan_state_t cur,
  input  ctc_pkg::item_t       item,
  output ctc_pkg::chan_state_t nxt,
  output ctc_pkg::result_t     res
);
  import ctc_pkg::*;

  logic [5:0] cw;
  logic [7:0] data;
  logic       wr_edge;
  logic       tc_expected;
  logic       wr_tc;
  logic       wr_cw;
  logic       soft_reset_word;
  logic       edge_change;
  logic       trig_edge;
  logic       in_reset;
  logic       pre_tick;
  logic       count_en;
  logic       cnt_zero;
  logic       zc;
  run_t       nst;

  always_comb begin
    cw   = cur.control_word;
    data = item.write_data;

    wr_edge         = item.write_strobe && !cur.strobe_prev;
    tc_expected     = cw[CW_TC_FOLLOWS] && (cur.run_state != RS_RESET);
    wr_tc           = wr_edge && tc_expected;
    wr_cw           = wr_edge && !tc_expected && data[DB_CONTROL];
    soft_reset_word = wr_cw && data[DB_SOFT_RESET];
    edge_change     = wr_cw && (data[DB_RISING] != cw[CW_RISING]);

    // a change of the active edge counts as an edge itself
    if (cw[CW_RISING]) begin
      trig_edge = (item.trigger_level && !cur.trigger_prev) || edge_change;
    end else begin
      trig_edge = (cur.trigger_prev && !item.trigger_level) || edge_change;
    end

    in_reset = (cur.run_state != RS_RUN);
    if (cw[CW_PRE256]) begin
      pre_tick = (cur.prescaler == 8'hff);
    end else begin
      pre_tick = (cur.prescaler[3:0] == 4'hf);
    end
    count_en = cw[CW_COUNTER] ? trig_edge : pre_tick;
    cnt_zero = (cur.down_counter == 8'd0);
    zc       = cnt_zero && !cur.counter_was_zero && (cur.run_state == RS_RUN);

    if (soft_reset_word) begin
      nst = data[DB_TC_FOLLOWS] ? RS_WAIT_TC : RS_RESET;
    end else begin
      case (cur.run_state)
        RS_RESET:     nst = (wr_cw && data[DB_TC_FOLLOWS]) ? RS_WAIT_TC : RS_RESET;
        RS_WAIT_TC:   nst = wr_tc ? RS_WAIT_TRIG : RS_WAIT_TC;
        RS_WAIT_TRIG: nst = (!cw[CW_COUNTER] && cw[CW_TRIG_START] && !trig_edge)
                            ? RS_WAIT_TRIG : RS_RUN;
        RS_RUN:       nst = RS_RUN;
        default:      nst = RS_RESET;
      endcase
    end

    nxt                  = cur;
    nxt.run_state        = nst;
    nxt.strobe_prev      = item.write_strobe;
    nxt.trigger_prev     = item.trigger_level;
    nxt.counter_was_zero = cnt_zero;
    nxt.prescaler        = in_reset ? 8'd0 : cur.prescaler + 8'd1;

    // reload on zero count or while not running
    if (in_reset || zc) begin
      nxt.down_counter = cur.time_constant;
    end else if (count_en) begin
      nxt.down_counter = cur.down_counter - 8'd1;
    end

    // control word write beats tc-follows clear beats interrupt enable write
    if (wr_cw) begin
      nxt.control_word = data[7:2];
    end else if (wr_tc) begin
      nxt.control_word = cw & 6'h3e;
    end else if (item.int_enable_write) begin
      nxt.control_word = cw;
      nxt.control_word[CW_INT_EN] = item.int_enable_value;
    end

    if (wr_tc) begin
      nxt.time_constant = data;
    end

    res.zero_count_pulse   = zc;
    res.counter_value      = nxt.down_counter;
    res.interrupt_enabled  = nxt.control_word[CW_INT_EN];
    res.expecting_constant = nxt.control_word[CW_TC_FOLLOWS] && (nst != RS_RESET);
  end

endmodule

// ----- hw/rtl/ctc_channel_clock.sv -----
// Counter/timer block with NUM_CHANNELS independent channels. Each input item is one
// peripheral clock for the channel named in s_tuser; it returns one result item with
// the zero-count pulse, the counter after that clock, the interrupt enable bit and the
// time-constant-expected flag. One item is taken every cycle while the output is not
// stalled, to any mix of channels; it is held in the input register, and its result is
// registered into the output register and presented once the output is not
// stalled. The rate is set by the per-channel state flops, which are read, stepped and written
// back in the same cycle, so an item sees the effect of the item just before it.
// Channel numbers at or beyond NUM_CHANNELS wrap modulo NUM_CHANNELS.
module ctc_channel_clock #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // write_strobe[0], write_data[8:1], trigger_level[9], int_enable_write[10],
  // int_enable_value[11], zero[15:12]
  input  logic [15:0] s_tdata,
  // channel_select[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // zero_count_pulse[0], counter_value[8:1], interrupt_enabled[9],
  // expecting_constant[10], zero[15:11]
  output logic [15:0] m_tdata
);
  import ctc_pkg::*;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  chan_state_t       chan [NUM_CHANNELS];
  logic              in_valid;
  item_t             in_item;
  logic [CH_W-1:0]   in_idx;
  logic [CH_W-1:0]   s_idx;
  logic [3:0]        s_wrap;
  chan_state_t       cur;
  chan_state_t       nxt;
  result_t           res;
  logic              advance;
  logic              fire;

  // wrap the channel number by repeated compare and subtract
  always_comb begin
    s_wrap = {2'b00, s_tuser};
    for (int k = 0; k < 3; k++) begin
      if (s_wrap >= 4'(NUM_CHANNELS)) begin
        s_wrap = s_wrap - 4'(NUM_CHANNELS);
      end
    end
  end

  assign s_idx    = s_wrap[CH_W-1:0];
  assign advance  = !m_tvalid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;
  assign cur      = chan[in_idx];

  ctc_chan_step u_step (
    .cur  (cur),
    .item (in_item),
    .nxt  (nxt),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        chan[i] <= '0;
      end
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        m_tvalid <= in_valid;
      end
      if (fire) begin
        chan[in_idx] <= nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_idx                   <= s_idx;
      in_item.write_strobe     <= s_tdata[0];
      in_item.write_data       <= s_tdata[8:1];
      in_item.trigger_level    <= s_tdata[9];
      in_item.int_enable_write <= s_tdata[10];
      in_item.int_enable_value <= s_tdata[11];
    end
    if (fire) begin
      m_tdata <= {5'b0, res.expecting_constant, res.interrupt_enabled,
                  res.counter_value, res.zero_count_pulse};
    end
  end

`ifndef SYNTH
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && m_tvalid && !m_tready))
    else $error("input stalled without a blocked output");

  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_item) && $stable(in_idx)))
    else $error("held item changed while output stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!in_valid && !m_tvalid))
    else $error("pipeline not empty after reset");
`endif

endmodule

// ----- sim/ctc_channel_clock_tb.sv -----
`timescale 1ns / 100ps

module ctc_channel_clock_tb;
  import ctc_pkg::*;

  localparam int NUM_CH       = 4;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  ctc_channel_clock #(
    .NUM_CHANNELS(NUM_CH)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  // Predicted channel state
  run_t       run_q      [NUM_CH];
  logic [5:0] ctl_q      [NUM_CH];
  logic [7:0] tconst_q   [NUM_CH];
  logic [7:0] presc_q    [NUM_CH];
  logic [7:0] count_q    [NUM_CH];
  logic       was_zero_q [NUM_CH];
  logic       strobe_q   [NUM_CH];
  logic       trig_q     [NUM_CH];

  result_t pending_results[$];

  int errors       = 0;
  int items_sent   = 0;
  int idle_pct     = 0;
  int stall_pct    = 0;
  bit hold_req     = 1'b0;
  int hold_left    = 0;
  int quiet_cycles = 0;

  always #10 clk = ~clk;

  task automatic clear_channels();
    for (int i = 0; i < NUM_CH; i++) begin
      run_q[i]      = RS_RESET;
      ctl_q[i]      = '0;
      tconst_q[i]   = '0;
      presc_q[i]    = '0;
      count_q[i]    = '0;
      was_zero_q[i] = 1'b0;
      strobe_q[i]   = 1'b0;
      trig_q[i]     = 1'b0;
    end
  endtask

  // Apply one clock to a channel and return what the block should report
  task automatic clock_channel(input logic [1:0] sel, input item_t it, output result_t r);
    int         c;
    logic [5:0] cw;
    run_t       st, nst;
    logic [7:0] ps, cnt;
    logic       counter_mode, pre256, rising, trig_start;
    logic       wr_edge, tc_expected, wr_tc, wr_cw, soft_reset, edge_change;
    logic       trig_edge, pre_tick, count_en, cnt_zero, zc;

    c  = sel % NUM_CH;
    cw = ctl_q[c];
    st = run_q[c];
    ps = presc_q[c];
    cnt = count_q[c];

    counter_mode = cw[CW_COUNTER];
    pre256       = cw[CW_PRE256];
    rising       = cw[CW_RISING];
    trig_start   = cw[CW_TRIG_START];

    wr_edge     = it.write_strobe && !strobe_q[c];
    tc_expected = cw[CW_TC_FOLLOWS] && (st != RS_RESET);
    wr_tc       = wr_edge && tc_expected;
    wr_cw       = wr_edge && !tc_expected && it.write_data[DB_CONTROL];
    soft_reset  = wr_cw && it.write_data[DB_SOFT_RESET];
    edge_change = wr_cw && (it.write_data[DB_RISING] != rising);
    trig_edge   = rising ? ((it.trigger_level && !trig_q[c]) || edge_change)
                         : ((trig_q[c] && !it.trigger_level) || edge_change);
    pre_tick    = pre256 ? (ps == 8'hff) : (ps[3:0] == 4'hf);
    count_en    = counter_mode ? trig_edge : pre_tick;
    cnt_zero    = (cnt == 8'h00);
    zc          = cnt_zero && !was_zero_q[c] && (st == RS_RUN);

    if (soft_reset) begin
      nst = it.write_data[DB_TC_FOLLOWS] ? RS_WAIT_TC : RS_RESET;
    end else begin
      case (st)
        RS_RESET: begin
          nst = (wr_cw && it.write_data[DB_TC_FOLLOWS]) ? RS_WAIT_TC : RS_RESET;
        end
        RS_WAIT_TC: begin
          nst = wr_tc ? RS_WAIT_TRIG : RS_WAIT_TC;
        end
        RS_WAIT_TRIG: begin
          nst = (!counter_mode && trig_start && !trig_edge) ? RS_WAIT_TRIG : RS_RUN;
        end
        default: begin
          nst = RS_RUN;
        end
      endcase
    end

    strobe_q[c]   = it.write_strobe;
    trig_q[c]     = it.trigger_level;
    was_zero_q[c] = cnt_zero;
    run_q[c]      = nst;
    presc_q[c]    = (st != RS_RUN) ? 8'h00 : ps + 8'h01;
    if ((st != RS_RUN) || zc) begin
      count_q[c] = tconst_q[c];
    end else if (count_en) begin
      count_q[c] = cnt - 8'h01;
    end
    // control word write beats the follows-bit clear, both beat the enable write
    if (wr_cw) begin
      ctl_q[c] = it.write_data[7:2];
    end else if (wr_tc) begin
      ctl_q[c] = cw;
      ctl_q[c][CW_TC_FOLLOWS] = 1'b0;
    end else if (it.int_enable_write) begin
      ctl_q[c] = cw;
      ctl_q[c][CW_INT_EN] = it.int_enable_value;
    end
    if (wr_tc) begin
      tconst_q[c] = it.write_data;
    end

    r.zero_count_pulse   = zc;
    r.counter_value      = count_q[c];
    r.interrupt_enabled  = ctl_q[c][CW_INT_EN];
    r.expecting_constant = ctl_q[c][CW_TC_FOLLOWS] && (nst != RS_RESET);
  endtask

  task automatic send_item(input logic [1:0] ch, input logic strobe, input logic [7:0] data,
                           input logic trig, input logic ie_wr, input logic ie_val);
    item_t   it;
    result_t r;

    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= ch;
    s_tdata  <= {4'b0, ie_val, ie_wr, trig, data, strobe};
    @(posedge clk);
    while (!s_tready) @(posedge clk);

    it.write_strobe     = strobe;
    it.write_data       = data;
    it.trigger_level    = trig;
    it.int_enable_write = ie_wr;
    it.int_enable_value = ie_val;
    clock_channel(ch, it, r);
    pending_results.push_back(r);
    items_sent++;
  endtask

  task automatic send_noise();
    send_item(2'($urandom_range(3)), 1'($urandom_range(1)), 8'($urandom_range(255)),
              1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // Program one channel: control word, usually a time constant, then a run of clocks
  task automatic send_program();
    logic [1:0] ch;
    logic [7:0] cw_byte;
    logic [7:0] tc_byte;
    logic       trig;
    int         len;

    ch      = 2'($urandom_range(3));
    trig    = trig_q[ch];
    cw_byte = 8'($urandom_range(255));
    cw_byte[DB_CONTROL] = 1'b1;
    if ($urandom_range(99) < 85) cw_byte[DB_TC_FOLLOWS] = 1'b1;
    if ($urandom_range(99) < 85) cw_byte[CW_PRE256 + 2] = 1'b0;

    send_item(ch, 1'b0, 8'($urandom_range(255)), trig, 1'b0, 1'b0);
    send_item(ch, 1'b1, cw_byte, trig, 1'b0, 1'b0);
    // now and then leave the constant out
    if ($urandom_range(99) < 90) begin
      tc_byte = ($urandom_range(99) < 80) ? 8'($urandom_range(1, 6)) : 8'($urandom_range(255));
      send_item(ch, 1'b0, 8'($urandom_range(255)), trig, 1'b0, 1'b0);
      send_item(ch, 1'b1, tc_byte, trig, 1'b0, 1'b0);
    end
    len = $urandom_range(8, 60);
    repeat (len) begin
      if ($urandom_range(99) < 10) send_noise();
      if ($urandom_range(99) < 50) trig = ~trig;
      send_item(ch, $urandom_range(99) < 4, 8'($urandom_range(255)), trig,
                $urandom_range(99) < 6, 1'($urandom_range(1)));
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    idle_pct  = 0;
    stall_pct = 0;
    send_item(2'd0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    // vector byte changes nothing, so the enable write goes through
    send_item(2'd3, 1'b1, 8'h02, 1'b1, 1'b1, 1'b1);
    send_item(2'd3, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0);
    // control word with every bit set wins over the enable write
    send_item(2'd1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    send_item(2'd1, 1'b1, 8'hff, 1'b0, 1'b1, 1'b0);
    send_item(2'd1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    // zero time constant; follows-bit clear wins over the enable write
    send_item(2'd1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1);
    send_item(2'd1, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0);
    repeat (3) begin
      send_item(2'd1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
      send_item(2'd1, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0);
    end
    // timer mode, largest constant
    send_item(2'd2, 1'b1, 8'h05, 1'b0, 1'b0, 1'b0);
    send_item(2'd2, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    send_item(2'd2, 1'b1, 8'hff, 1'b0, 1'b0, 1'b0);
    send_item(2'd2, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    send_item(2'd2, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0);
    // soft reset word without a constant to follow
    send_item(2'd2, 1'b1, 8'h03, 1'b0, 1'b0, 1'b0);
    send_item(2'd2, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                     input int count);
    int start;

    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    start     = items_sent;
    while (items_sent - start < count) begin
      if ($urandom_range(99) < 80) send_program();
      else send_noise();
    end
    wait_drained();
  endtask

  task automatic test_input_stall();
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1'b1;
    repeat (60) send_noise();
    wait_drained();
  endtask

  // Result side: stall pattern plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      m_tready  <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_req  = 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic note_mismatch(input string what, input result_t exp, input result_t got);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("%0t: %s: expected zc=%0d cnt=%0d ie=%0d tce=%0d, got zc=%0d cnt=%0d ie=%0d tce=%0d",
               $realtime, what, exp.zero_count_pulse, exp.counter_value,
               exp.interrupt_enabled, exp.expecting_constant, got.zero_count_pulse,
               got.counter_value, got.interrupt_enabled, got.expecting_constant);
    end
  endtask

  always @(posedge clk) begin
    result_t exp;
    result_t got;
    string   bad;

    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
      if (m_tvalid && m_tready) begin
        got.zero_count_pulse   = m_tdata[0];
        got.counter_value      = m_tdata[8:1];
        got.interrupt_enabled  = m_tdata[9];
        got.expecting_constant = m_tdata[10];
        if (pending_results.size() == 0) begin
          note_mismatch("result with nothing pending", '0, got);
        end else begin
          exp = pending_results.pop_front();
          bad = "";
          if (got.zero_count_pulse !== exp.zero_count_pulse) bad = {bad, " zero_count_pulse"};
          if (got.counter_value !== exp.counter_value) bad = {bad, " counter_value"};
          if (got.interrupt_enabled !== exp.interrupt_enabled) bad = {bad, " interrupt_enabled"};
          if (got.expecting_constant !== exp.expecting_constant) bad = {bad, " expecting_constant"};
          if (bad != "") note_mismatch({"mismatch in", bad}, exp, got);
        end
      end
    end
  end

  initial begin
    clear_channels();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    wait_drained();
    test_random_traffic(0, 0, 150);
    test_random_traffic(75, 0, 150);
    test_random_traffic(0, 75, 150);
    test_random_traffic(15, 15, 150);
    test_input_stall();

    wait_drained();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
